### sv/weigh_settle_ack_sequencer_macros.svh
// Assertion macros for the weigh/settle/ack sequencer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WEIGH_SETTLE_ACK_SEQUENCER_MACROS_SVH
`define WEIGH_SETTLE_ACK_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define WSAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("weigh_settle_ack_sequencer: check failed");
// next-cycle implication
`define WSAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("weigh_settle_ack_sequencer: check failed");
`else
`define WSAS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSAS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/wsas_pkg.sv
// Shared types and constants for the weigh/settle/ack sequencer.
// No dependencies; used by every module of the block.
package wsas_pkg;

	// phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_STAB  = 2'd1;
	localparam logic [1:0] PH_AWAIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// outcome codes
	localparam logic [1:0] OC_SENT     = 2'd0;
	localparam logic [1:0] OC_UNSENT   = 2'd1;
	localparam logic [1:0] OC_UNSTABLE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_READER_PRESENT = 3'd0;
	localparam logic [2:0] CFG_STABLE_RANGE   = 3'd1;
	localparam logic [2:0] CFG_STABLE_HOLD    = 3'd2;
	localparam logic [2:0] CFG_SETTLE_MIN     = 3'd3;
	localparam logic [2:0] CFG_SETTLE_TIMEOUT = 3'd4;
	localparam logic [2:0] CFG_ACK_TIMEOUT    = 3'd5;
	localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd6;
	localparam logic [2:0] CFG_DONE_HOLD      = 3'd7;

	// configuration reset values
	localparam logic [15:0] RST_STABLE_RANGE   = 16'd32;
	localparam logic [31:0] RST_STABLE_HOLD    = 32'd1500;
	localparam logic [31:0] RST_SETTLE_MIN     = 32'd2000;
	localparam logic [31:0] RST_SETTLE_TIMEOUT = 32'd20000;
	localparam logic [31:0] RST_ACK_TIMEOUT    = 32'd3000;
	localparam logic [2:0]  RST_RETRY_LIMIT    = 3'd4;
	localparam logic [31:0] RST_DONE_HOLD      = 32'd3000;

	// tag must be missing this long before the result re-arms
	localparam logic [31:0] TAG_GONE_MS = 32'd500;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               tag_seen;
		logic [55:0]        tag_id;
		logic [2:0]         tag_id_bytes;
		logic               window_ok;
		logic [19:0]        window_spread;
		logic signed [23:0] window_mean;
		logic [31:0]        window_age_ms;
		logic               link_up;
		logic               ack_valid;
		logic [31:0]        ack_id;
	} item_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic [1:0]         outcome;
		logic               send_now;
		logic [31:0]        event_number;
		logic signed [23:0] captured_weight;
		logic [55:0]        active_tag;
		logic [2:0]         active_tag_bytes;
		logic [2:0]         resend_count;
		logic               busy_res;
	} result_t;

	typedef struct packed {
		logic        reader_present;
		logic [15:0] stable_range_limit;
		logic [31:0] stable_hold_ms;
		logic [31:0] settle_floor_ms;
		logic [31:0] settle_timeout_ms;
		logic [31:0] resend_wait_ms;
		logic [2:0]  retry_limit;
		logic [31:0] done_hold_ms;
	} cfg_t;

	// keep only the low 'bytes' bytes of a UID
	function automatic logic [55:0] tag_mask(input logic [2:0] bytes);
		logic [55:0] m;
		m = '0;
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < bytes) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

### sv/wsas_cfg_regs.sv
// Configuration register file for the weigh/settle/ack sequencer.
// Depends on wsas_pkg (cfg_t, register indexes, reset values).
module wsas_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output wsas_pkg::cfg_t cfg
);
	import wsas_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reader_present     <= 1'b0;
			cfg_q.stable_range_limit <= RST_STABLE_RANGE;
			cfg_q.stable_hold_ms     <= RST_STABLE_HOLD;
			cfg_q.settle_floor_ms    <= RST_SETTLE_MIN;
			cfg_q.settle_timeout_ms  <= RST_SETTLE_TIMEOUT;
			cfg_q.resend_wait_ms     <= RST_ACK_TIMEOUT;
			cfg_q.retry_limit        <= RST_RETRY_LIMIT;
			cfg_q.done_hold_ms       <= RST_DONE_HOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_READER_PRESENT: cfg_q.reader_present     <= cfg_data[0];
				CFG_STABLE_RANGE:   cfg_q.stable_range_limit <= cfg_data[15:0];
				CFG_STABLE_HOLD:    cfg_q.stable_hold_ms     <= cfg_data;
				CFG_SETTLE_MIN:     cfg_q.settle_floor_ms    <= cfg_data;
				CFG_SETTLE_TIMEOUT: cfg_q.settle_timeout_ms  <= cfg_data;
				CFG_ACK_TIMEOUT:    cfg_q.resend_wait_ms     <= cfg_data;
				CFG_RETRY_LIMIT:    cfg_q.retry_limit        <= cfg_data[2:0];
				CFG_DONE_HOLD:      cfg_q.done_hold_ms       <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### sv/wsas_core.sv
// Sequencer state and one-tick update logic.
// Depends on wsas_pkg; state moves only when step is high.
module wsas_core (
	input  logic             clk,
	input  logic             arst_n,
	input  wsas_pkg::cfg_t   cfg,
	input  wsas_pkg::item_t  item,
	input  logic             step,
	output wsas_pkg::result_t res
);
	import wsas_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = PH_IDLE,
		ST_STAB  = PH_STAB,
		ST_AWAIT = PH_AWAIT,
		ST_DONE  = PH_DONE
	} phase_t;

	// state
	phase_t             phase_q, phase_n;
	logic [1:0]         outcome_q, outcome_n;
	logic [55:0]        held_tag_q, held_tag_n;
	logic [2:0]         held_bytes_q, held_bytes_n;
	logic [31:0]        ident_time_q, ident_time_n;
	logic [31:0]        stable_start_q, stable_start_n;
	logic               stable_flag_q, stable_flag_n;
	logic [31:0]        absent_start_q, absent_start_n;
	logic               absent_flag_q, absent_flag_n;
	logic [31:0]        done_time_q, done_time_n;
	logic signed [23:0] weight_q, weight_n;
	logic [31:0]        event_ctr_q, event_ctr_n;
	logic [31:0]        pending_q, pending_n;
	logic [31:0]        publish_time_q, publish_time_n;
	logic [2:0]         resend_q, resend_n;

	// tick scratch
	logic [55:0] tid;
	logic        ack_hit;
	phase_t      ph_eff;
	logic        settled;
	logic        send;
	logic        same_tag;
	logic [31:0] el_id;
	logic [31:0] el_pub;

	always_comb begin
		phase_n        = phase_q;
		outcome_n      = outcome_q;
		held_tag_n     = held_tag_q;
		held_bytes_n   = held_bytes_q;
		ident_time_n   = ident_time_q;
		stable_start_n = stable_start_q;
		stable_flag_n  = stable_flag_q;
		absent_start_n = absent_start_q;
		absent_flag_n  = absent_flag_q;
		done_time_n    = done_time_q;
		weight_n       = weight_q;
		event_ctr_n    = event_ctr_q;
		pending_n      = pending_q;
		publish_time_n = publish_time_q;
		resend_n       = resend_q;
		send           = 1'b0;
		settled        = 1'b0;
		same_tag       = 1'b0;

		tid     = item.tag_id & tag_mask(item.tag_id_bytes);
		el_id   = item.now_ms - ident_time_q;
		el_pub  = item.now_ms - publish_time_q;

		// ack is honored even with no reader; with a reader present, done logic then runs in the same tick
		ack_hit = item.ack_valid && (item.ack_id == pending_q) && (phase_q == ST_AWAIT);
		ph_eff  = ack_hit ? ST_DONE : phase_q;
		if (ack_hit) begin
			phase_n     = ST_DONE;
			outcome_n   = OC_SENT;
			done_time_n = item.now_ms;
		end

		if (cfg.reader_present) begin
			case (ph_eff)
				ST_IDLE: begin
					if (item.tag_seen) begin
						held_tag_n    = tid;
						held_bytes_n  = item.tag_id_bytes;
						ident_time_n  = item.now_ms;
						stable_flag_n = 1'b0;
						phase_n       = ST_STAB;
					end
				end
				ST_STAB: begin
					settled = item.window_ok
						&& (item.window_spread < {4'd0, cfg.stable_range_limit})
						&& (item.window_age_ms >= cfg.settle_floor_ms);
					stable_flag_n = settled;
					if (settled && !stable_flag_q) begin
						stable_start_n = item.now_ms;
					end
					if (stable_flag_n && ((item.now_ms - stable_start_n) >= cfg.stable_hold_ms)
						&& (el_id >= cfg.settle_floor_ms)) begin
						weight_n       = item.window_mean;
						event_ctr_n    = event_ctr_q + 32'd1;
						pending_n      = event_ctr_q + 32'd1;
						resend_n       = 3'd0;
						send           = 1'b1;
						publish_time_n = item.now_ms;
						phase_n        = ST_AWAIT;
					end else if (el_id > cfg.settle_timeout_ms) begin
						outcome_n   = OC_UNSTABLE;
						done_time_n = item.now_ms;
						phase_n     = ST_DONE;
					end
				end
				ST_AWAIT: begin
					if (item.link_up && (el_pub > cfg.resend_wait_ms)) begin
						if (resend_q < cfg.retry_limit) begin
							resend_n       = resend_q + 3'd1;
							send           = 1'b1;
							publish_time_n = item.now_ms;
						end else begin
							outcome_n   = OC_UNSENT;
							done_time_n = item.now_ms;
							phase_n     = ST_DONE;
						end
					end
				end
				default: begin
					same_tag = item.tag_seen && (tid == held_tag_q)
						&& (item.tag_id_bytes == held_bytes_q);
					if (same_tag) begin
						absent_flag_n = 1'b0;
					end else if (!absent_flag_q) begin
						absent_flag_n  = 1'b1;
						absent_start_n = item.now_ms;
					end
					if (((item.now_ms - done_time_n) >= cfg.done_hold_ms) && absent_flag_n
						&& ((item.now_ms - absent_start_n) >= TAG_GONE_MS)) begin
						phase_n = ST_IDLE;
					end
				end
			endcase
		end
	end

	always_comb begin
		res.phase            = phase_n;
		res.outcome          = outcome_n;
		res.send_now         = send;
		res.event_number     = pending_n;
		res.captured_weight  = weight_n;
		res.active_tag       = held_tag_n;
		res.active_tag_bytes = held_bytes_n;
		res.resend_count     = resend_n;
		res.busy_res         = (phase_n == ST_STAB) || (phase_n == ST_AWAIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= ST_IDLE;
			outcome_q      <= OC_SENT;
			held_tag_q     <= '0;
			held_bytes_q   <= '0;
			ident_time_q   <= '0;
			stable_start_q <= '0;
			stable_flag_q  <= 1'b0;
			absent_start_q <= '0;
			absent_flag_q  <= 1'b0;
			done_time_q    <= '0;
			weight_q       <= '0;
			event_ctr_q    <= '0;
			pending_q      <= '0;
			publish_time_q <= '0;
			resend_q       <= '0;
		end else if (step) begin
			phase_q        <= phase_n;
			outcome_q      <= outcome_n;
			held_tag_q     <= held_tag_n;
			held_bytes_q   <= held_bytes_n;
			ident_time_q   <= ident_time_n;
			stable_start_q <= stable_start_n;
			stable_flag_q  <= stable_flag_n;
			absent_start_q <= absent_start_n;
			absent_flag_q  <= absent_flag_n;
			done_time_q    <= done_time_n;
			weight_q       <= weight_n;
			event_ctr_q    <= event_ctr_n;
			pending_q      <= pending_n;
			publish_time_q <= publish_time_n;
			resend_q       <= resend_n;
		end
	end

endmodule

### sv/weigh_settle_ack_sequencer.sv
// Weigh/settle/ack sequencer: poll-tick driven measurement and publish controller.
// One result transfer per accepted tick, in order. Ticks can be accepted every cycle
// while item_stall is low; each tick passes through the input register, then the state
// update into the result register. Throughput is one tick per cycle while result_stall
// is low. The input register acts as a skid stage: a new tick is still taken while a
// finished result waits for its transfer, and item_stall rises only when both stages
// are full and result_stall is high. Configuration writes are always ready and are
// meant to be issued while no tick is in flight. Depends on wsas_pkg, wsas_cfg_regs,
// wsas_core and the macros header.
module weigh_settle_ack_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	// tick input
	input  logic              item_valid,
	output logic              item_stall,
	input  wsas_pkg::item_t   item,
	// result output
	output logic              result_valid,
	input  logic              result_stall,
	output wsas_pkg::result_t result,
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import wsas_pkg::*;
	`include "weigh_settle_ack_sequencer_macros.svh"

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t res_next;
	logic    advance;

	wsas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the tick in s1 is processed (and state committed) when the result slot frees up
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;

	wsas_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (advance),
		.res    (res_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// checks
	`WSAS_ASSERT_IMP(a_stall_needs_tick, clk, arst_n, item_stall, valid_s1)
	`WSAS_ASSERT_NXT(a_advance_fills_out, clk, arst_n, advance, valid_s2)
	`WSAS_ASSERT_IMP(a_send_only_await, clk, arst_n, valid_s2 && result_s2.send_now,
		result_s2.phase == PH_AWAIT)
	`WSAS_ASSERT_IMP(a_busy_matches_phase, clk, arst_n, valid_s2,
		result_s2.busy_res == ((result_s2.phase == PH_STAB) || (result_s2.phase == PH_AWAIT)))

endmodule
